>>> rtl/core/sync_header_crc16_frame_receiver_core_assert.svh
// assertion macros shared by the receiver rtl
// each macro expects signals named clk and rst in the using module
`ifndef SYNC_HEADER_CRC16_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SYNC_HEADER_CRC16_FRAME_RECEIVER_CORE_ASSERT_SVH

// condition holds on every clock edge out of reset
`define SHCFR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle implies another condition in the next cycle
`define SHCFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/shcfr_pkg.sv
package shcfr_pkg;

  localparam logic [7:0] SYNC_A = 8'h1A;
  localparam logic [7:0] SYNC_B = 8'h72;
  localparam logic [7:0] SYNC_C = 8'h73;

  localparam int HDR_BYTES = 7;
  localparam int HDR_IDX_W = 3;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

  // body length counts the two trailing crc bytes
  localparam logic [15:0] CRC_BYTES = 16'd2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY      = 3'd0,
    CFG_START     = 3'd1,
    CFG_OUT_XOR   = 3'd2,
    CFG_REFLECTED = 3'd3,
    CFG_MAX_LEN   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC_B = 3'd1,
    PH_SYNC_C = 3'd2,
    PH_HEADER = 3'd3,
    PH_BODY   = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_LEN_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  cmd_class;
    logic [7:0]  cmd_sub;
    logic [7:0]  frame_number;
    logic [15:0] extra_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    status_t     status;
    logic        last;
  } result_t;

  // crc settings seen by the byte update unit
  typedef struct packed {
    logic [15:0] poly;
    logic        reflected;
  } crc_cfg_t;

endpackage

>>> rtl/core/shcfr_crc_byte.sv
module shcfr_crc_byte import shcfr_pkg::*; (
  input  crc_cfg_t    cfg,
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  // one byte of crc-16, eight bit steps either msb or lsb first
  always_comb begin
    logic [15:0] c;
    logic [15:0] rpoly;
    for (int i = 0; i < 16; i++) begin
      rpoly[i] = cfg.poly[15-i];
    end
    if (cfg.reflected) begin
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
      end
    end else begin
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ cfg.poly) : (c << 1);
      end
    end
    crc_out = c;
  end

endmodule

>>> rtl/core/sync_header_crc16_frame_receiver_core.sv
// channel  | dir | handshake          | payload
// s_axis   | in  | s_tvalid/s_tready  | s_tdata: received byte
// m_axis   | out | m_tvalid/m_tready  | m_tdata: frame fields, m_tuser: kind, m_tlast
// cfg      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one byte per cycle while s_tready is high; each byte is decoded in the cycle of its
// transfer, and its result is registered in the output register or the skid slot
// the byte-wide crc update is the deepest path from s_tdata to the state regs
// rst is synchronous, clears the phase, counters, crc and both output slots
// a stalled output keeps accepting: the second result goes to a skid slot,
// s_tready drops only while that slot is occupied
// cfg_ready is always high, writes take effect on the next byte
`include "sync_header_crc16_frame_receiver_core_assert.svh"

module sync_header_crc16_frame_receiver_core import shcfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] cmd_class, [15:8] cmd_sub, [23:16] frame_number, [39:24] extra_code,
  // [55:40] payload_length, [63:56] data_byte, [65:64] status, [71:66] zero
  output logic [71:0]          m_tdata,
  output logic [1:0]           m_tuser,   // [1:0] kind
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // configuration registers
  logic [15:0] crc_poly;
  logic [15:0] crc_start;
  logic [15:0] crc_out_xor;
  logic        crc_reflected;
  logic [15:0] max_body_length;

  // receive state
  phase_t               phase, phase_next;
  logic [HDR_IDX_W-1:0] header_index, header_index_next;
  logic [15:0]          bytes_left, bytes_left_next;
  logic [15:0]          crc_running, crc_running_next;
  logic [7:0]           crc_high_seen, crc_high_seen_next;
  logic [7:0]           header_store [HDR_BYTES];
  logic                 store_we;

  // output register and skid slot
  logic    out_valid, skid_valid;
  result_t out_res, skid_res, res;
  logic    res_valid;

  logic        in_xfer, out_xfer;
  logic        restart;
  logic [15:0] crc_seed, crc_calc;
  logic [15:0] len_store, len_new, left_dec;
  crc_cfg_t    crc_cfg;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly        <= 16'h1021;
      crc_start       <= 16'hFFFF;
      crc_out_xor     <= 16'h0000;
      crc_reflected   <= 1'b0;
      max_body_length <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLY:      crc_poly        <= cfg_data;
        CFG_START:     crc_start       <= cfg_data;
        CFG_OUT_XOR:   crc_out_xor     <= cfg_data;
        CFG_REFLECTED: crc_reflected   <= cfg_data[0];
        CFG_MAX_LEN:   max_body_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // a byte that breaks the sync sequence is retried as a first sync byte,
  // so the crc is seeded fresh whenever the hunt starts over
  assign restart = (phase == PH_HUNT) ||
                   (phase == PH_SYNC_B && s_tdata != SYNC_B) ||
                   (phase == PH_SYNC_C && s_tdata != SYNC_C);
  assign crc_seed  = restart ? crc_start : crc_running;
  assign crc_cfg   = '{poly: crc_poly, reflected: crc_reflected};
  assign len_store = {header_store[5], header_store[6]};
  assign len_new   = {header_store[5], s_tdata};
  assign left_dec  = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;

  shcfr_crc_byte u_crc (
    .cfg     (crc_cfg),
    .crc_in  (crc_seed),
    .data    (s_tdata),
    .crc_out (crc_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_index  <= '0;
      bytes_left    <= 16'd0;
      crc_running   <= 16'd0;
      crc_high_seen <= 8'd0;
    end else begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      bytes_left    <= bytes_left_next;
      crc_running   <= crc_running_next;
      crc_high_seen <= crc_high_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      header_store[header_index] <= s_tdata;
    end
  end

  // next state and the result of the byte in transfer
  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    bytes_left_next    = bytes_left;
    crc_running_next   = crc_running;
    crc_high_seen_next = crc_high_seen;
    store_we           = 1'b0;
    res_valid          = 1'b0;
    res.kind           = KIND_HEADER;
    res.cmd_class      = header_store[0];
    res.cmd_sub        = header_store[1];
    res.frame_number   = header_store[2];
    res.extra_code     = {header_store[3], header_store[4]};
    res.payload_length = len_store - CRC_BYTES;
    res.data_byte      = 8'd0;
    res.status         = ST_OK;
    res.last           = 1'b0;
    if (in_xfer) begin
      case (phase)
        PH_HUNT, PH_SYNC_B, PH_SYNC_C: begin
          if (restart) begin
            if (s_tdata == SYNC_A) begin
              crc_running_next = crc_calc;
              phase_next       = PH_SYNC_B;
            end else begin
              phase_next = PH_HUNT;
            end
          end else begin
            crc_running_next = crc_calc;
            if (phase == PH_SYNC_C) begin
              phase_next        = PH_HEADER;
              header_index_next = '0;
            end else begin
              phase_next = PH_SYNC_C;
            end
          end
        end
        PH_HEADER: begin
          crc_running_next = crc_calc;
          store_we         = 1'b1;
          if (header_index == HDR_LAST) begin
            header_index_next = '0;
            res_valid         = 1'b1;
            if (len_new < CRC_BYTES || len_new > max_body_length) begin
              // bad length closes the frame right away
              phase_next         = PH_HUNT;
              res.kind           = KIND_END;
              res.payload_length = 16'd0;
              res.status         = ST_LEN_BAD;
              res.last           = 1'b1;
            end else begin
              bytes_left_next    = len_new - CRC_BYTES;
              phase_next         = (len_new == CRC_BYTES) ? PH_CRC_HI : PH_BODY;
              res.payload_length = len_new - CRC_BYTES;
            end
          end else begin
            header_index_next = header_index + HDR_IDX_W'(1);
          end
        end
        PH_BODY: begin
          crc_running_next = crc_calc;
          bytes_left_next  = left_dec;
          if (left_dec == 16'd0) begin
            phase_next = PH_CRC_HI;
          end
          res_valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = s_tdata;
        end
        PH_CRC_HI: begin
          crc_high_seen_next = s_tdata;
          phase_next         = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          res.kind   = KIND_END;
          res.last   = 1'b1;
          res.status = ({crc_high_seen, s_tdata} == (crc_running ^ crc_out_xor)) ?
                       ST_OK : ST_CRC_BAD;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // output register with skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_xfer) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_res <= skid_res;
      end
    end else if (res_valid) begin
      if (!out_valid || out_xfer) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {6'b000000, out_res.status, out_res.data_byte, out_res.payload_length,
                     out_res.extra_code, out_res.frame_number, out_res.cmd_sub,
                     out_res.cmd_class};

  `SHCFR_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid,
    "skid slot holds a result while the output register is empty")
  `SHCFR_ASSERT_NEXT(a_skid_drains, skid_valid && out_xfer, out_valid && !skid_valid,
    "skid slot did not move into the output register")
  `SHCFR_ASSERT_ALWAYS(a_header_index_range, header_index <= HDR_LAST,
    "header index ran past the header")
  `SHCFR_ASSERT_ALWAYS(a_body_has_bytes, phase != PH_BODY || bytes_left != 16'd0,
    "payload phase with no bytes left")

endmodule
